>>> src/ibf_pkg.sv
// Shared types and constants of the image bloom filter unit.
// Depends on nothing; the divider, the top level and the testbench import it.
package ibf_pkg;

   localparam int MAX_WIDTH      = 256;
   localparam int MAX_HEIGHT     = 256;
   localparam int MAX_HALF_WIDTH = 16;
   localparam int CHANNEL_BITS   = 16;

   localparam int COORD_BITS  = 8;
   localparam int FRAME_AW    = 2 * COORD_BITS;
   localparam int PIXEL_BITS  = 3 * CHANNEL_BITS;
   localparam int WEIGHT_BITS = 17;
   localparam int WEIGHT_AW   = 8;
   localparam int WSUM_BITS   = 27;
   localparam int ACC_BITS    = WSUM_BITS + CHANNEL_BITS;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_FILTER = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_HALF   = 2'd2,
      CSR_MIX    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CENTER,
      ST_WALK,
      ST_DRAIN,
      ST_DECIDE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MIX_MUL,
      ST_MIX_ADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    done;
      logic [CHANNEL_BITS-1:0] quotient;
   } div_status_type;

endpackage

>>> src/ibf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module ibf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ibf_divider.sv
// Restoring divider, one quotient bit per cycle, for the weighted average.
// Depends on ibf_pkg; the quotient is known to fit in one channel.
module ibf_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ibf_pkg::ACC_BITS-1:0]  dividend,
   input  logic [ibf_pkg::WSUM_BITS-1:0] divisor,
   output ibf_pkg::div_status_type       status
);
   import ibf_pkg::*;

   localparam int CNT_BITS = $clog2(CHANNEL_BITS + 1);

   logic [WSUM_BITS-1:0]    rem_ff, rem_in;
   logic [CHANNEL_BITS-1:0] shift_ff, shift_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [WSUM_BITS:0]      trial;
   logic                    fits;

   always_comb begin
      trial    = {rem_ff, shift_ff[CHANNEL_BITS-1]};
      fits     = trial >= {1'b0, divisor};
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = dividend[ACC_BITS-1:CHANNEL_BITS];
         shift_in = dividend[CHANNEL_BITS-1:0];
         cnt_in   = CNT_BITS'(CHANNEL_BITS);
      end else if (cnt_ff != '0) begin
         rem_in   = fits ? WSUM_BITS'(trial - {1'b0, divisor}) : trial[WSUM_BITS-1:0];
         shift_in = {shift_ff[CHANNEL_BITS-2:0], fits};
         cnt_in   = cnt_ff - 1'b1;
         done_in  = cnt_ff == CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = shift_ff;

endmodule

>>> src/image_bloom_filter_unit.sv
// Top level of the image bloom filter unit: command port, frame and weight memories,
// window walk, accumulation, division and blend. Depends on ibf_pkg, ibf_ram, ibf_divider.
//
// Weight loads and pixel writes never raise busy. A filter request holds busy while the
// walk reads the window pixels left after clipping to the image (up to 1089), one window
// pixel per cycle from the frame memory; then one shared divider serves each of the three
// channels in turn, each followed by a blend multiply and a blend add. With a zero weight
// sum the division and blend are skipped and the centre pixel is returned. The result is
// shown for a single cycle with rsp_valid and cannot be held off, so it must be taken at
// once. Memories need no clearing.
module image_bloom_filter_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_type,
   input  logic [ibf_pkg::COORD_BITS-1:0]   req_pos_x,
   input  logic [ibf_pkg::COORD_BITS-1:0]   req_pos_y,
   input  logic [ibf_pkg::WEIGHT_AW-1:0]    req_table_index,
   input  logic [ibf_pkg::WEIGHT_BITS-1:0]  req_table_value,
   input  logic [ibf_pkg::CHANNEL_BITS-1:0] req_in_red,
   input  logic [ibf_pkg::CHANNEL_BITS-1:0] req_in_green,
   input  logic [ibf_pkg::CHANNEL_BITS-1:0] req_in_blue,
   output logic                             rsp_valid,
   output logic [ibf_pkg::CHANNEL_BITS-1:0] rsp_out_red,
   output logic [ibf_pkg::CHANNEL_BITS-1:0] rsp_out_green,
   output logic [ibf_pkg::CHANNEL_BITS-1:0] rsp_out_blue,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [16:0]                      csr_wdata
);
   import ibf_pkg::*;

   localparam int CB = CHANNEL_BITS;

   state_type state_ff, state_in;

   logic [8:0]  width_ff, height_ff;
   logic [4:0]  half_ff;
   logic [16:0] mix_ff;

   logic [8:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [8:0] bx_ff, bx_in, by_ff, by_in;
   logic [7:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [9:0] lim_ff, lim_in;
   logic [PIXEL_BITS-1:0] center_ff, center_in;
   logic       v1_ff, v1_in, v2_ff, v2_in;
   logic [WEIGHT_BITS-1:0] wt_ff, wt_in;
   logic [WEIGHT_BITS+CB-1:0] prod_ff [3];
   logic [WEIGHT_BITS+CB-1:0] prod_in [3];
   logic [ACC_BITS-1:0] acc_ff [3];
   logic [ACC_BITS-1:0] acc_in [3];
   logic [WSUM_BITS-1:0] wsum_ff, wsum_in;
   logic [1:0]  drain_ff, drain_in;
   logic [1:0]  ch_ff, ch_in;
   logic [CB-1:0] bloom_ff, bloom_in;
   logic signed [WEIGHT_BITS+CB+1:0] mprod_ff, mprod_in;
   logic [CB-1:0] res_ff [3];
   logic [CB-1:0] res_in [3];

   logic accept, do_load, do_write, do_filter;
   logic [FRAME_AW-1:0] frame_rd_addr;
   logic [PIXEL_BITS-1:0] frame_rd_data;
   logic [WEIGHT_BITS-1:0] weight_rd_data;
   logic div_start;
   div_status_type div_status;

   logic [8:0] w_clamp, h_clamp;
   logic [4:0] hw_clamp;
   logic [8:0] cx_hi, cy_hi;
   logic signed [9:0] dx, dy;
   logic [4:0] adx, ady;
   logic [9:0] d2;
   logic walk_valid, row_end, last_px, empty;
   logic [CB-1:0] pix_sel;
   logic signed [CB:0] diff;
   logic signed [CB+3:0] sum_mix;

   assign accept    = start && !busy;
   assign do_load   = accept && req_type == REQ_LOAD;
   assign do_write  = accept && req_type == REQ_WRITE;
   assign do_filter = accept && req_type == REQ_FILTER;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'(MAX_WIDTH);
         height_ff <= 9'(MAX_HEIGHT);
         half_ff   <= '0;
         mix_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata[8:0];
            CSR_HEIGHT: height_ff <= csr_wdata[8:0];
            CSR_HALF:   half_ff   <= csr_wdata[4:0];
            CSR_MIX:    mix_ff    <= csr_wdata;
            default:    ;
         endcase
      end
   end

   assign frame_rd_addr = (state_ff == ST_WALK) ? {by_ff[7:0], bx_ff[7:0]}
                                                : {req_pos_y, req_pos_x};

   ibf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_frame (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr ({req_pos_y, req_pos_x}),
      .wr_data ({req_in_red, req_in_green, req_in_blue}),
      .rd_addr (frame_rd_addr),
      .rd_data (frame_rd_data)
   );

   ibf_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << WEIGHT_AW)) u_weight (
      .clock   (clock),
      .wr_en   (do_load),
      .wr_addr (req_table_index),
      .wr_data (req_table_value),
      .rd_addr (d2[WEIGHT_AW-1:0]),
      .rd_data (weight_rd_data)
   );

   ibf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff[ch_ff]),
      .divisor  (wsum_ff),
      .status   (div_status)
   );

   always_comb begin
      w_clamp  = (width_ff == '0) ? 9'd1 :
                 (width_ff > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_ff;
      h_clamp  = (height_ff == '0) ? 9'd1 :
                 (height_ff > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_ff;
      hw_clamp = (half_ff > 5'(MAX_HALF_WIDTH)) ? 5'(MAX_HALF_WIDTH) : half_ff;
      cx_hi    = 9'(req_pos_x) + 9'(hw_clamp);
      cy_hi    = 9'(req_pos_y) + 9'(hw_clamp);
      dx       = signed'(10'(cx_ff)) - signed'(10'(bx_ff));
      dy       = signed'(10'(cy_ff)) - signed'(10'(by_ff));
      adx      = dx[9] ? 5'(-dx) : dx[4:0];
      ady      = dy[9] ? 5'(-dy) : dy[4:0];
      d2       = 10'(adx) * 10'(adx) + 10'(ady) * 10'(ady);
      walk_valid = d2 != '0 && d2 < lim_ff;
      row_end  = bx_ff == x1_ff;
      last_px  = row_end && by_ff == y1_ff;
      empty    = x0_ff > x1_ff || y0_ff > y1_ff;
      pix_sel  = center_ff[PIXEL_BITS-1-CB*ch_ff -: CB];
      diff     = signed'({1'b0, bloom_ff}) - signed'({1'b0, pix_sel});
      sum_mix  = signed'((CB+4)'(pix_sel)) + (CB+4)'(mprod_ff >>> 16);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (do_filter) state_in = ST_CENTER;
         ST_CENTER:    state_in = empty ? ST_DRAIN : ST_WALK;
         ST_WALK:      if (last_px) state_in = ST_DRAIN;
         ST_DRAIN:     if (drain_ff == 2'd1) state_in = ST_DECIDE;
         ST_DECIDE:    state_in = (wsum_ff == '0) ? ST_DONE : ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (div_status.done) state_in = ST_MIX_MUL;
         ST_MIX_MUL:   state_in = ST_MIX_ADD;
         ST_MIX_ADD:   state_in = (ch_ff == 2'd2) ? ST_DONE : ST_DIV_START;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = state_ff != ST_IDLE;
      rsp_valid = state_ff == ST_DONE;
      div_start = state_ff == ST_DIV_START;
   end

   always_comb begin
      x0_in = x0_ff; x1_in = x1_ff; y0_in = y0_ff; y1_in = y1_ff;
      cx_in = cx_ff; cy_in = cy_ff; lim_in = lim_ff;
      bx_in = bx_ff; by_in = by_ff;
      center_in = center_ff;
      v1_in = 1'b0;
      v2_in = v1_ff;
      wt_in = weight_rd_data;
      wsum_in = wsum_ff;
      drain_in = drain_ff;
      ch_in = ch_ff;
      bloom_in = bloom_ff;
      mprod_in = mprod_ff;
      for (int j = 0; j < 3; j++) begin
         prod_in[j] = (WEIGHT_BITS+CB)'(weight_rd_data) *
                      (WEIGHT_BITS+CB)'(frame_rd_data[PIXEL_BITS-1-CB*j -: CB]);
         acc_in[j]  = acc_ff[j];
         res_in[j]  = res_ff[j];
      end
      if (v2_ff) begin
         wsum_in = wsum_ff + WSUM_BITS'(wt_ff);
         for (int j = 0; j < 3; j++) begin
            acc_in[j] = acc_ff[j] + ACC_BITS'(prod_ff[j]);
         end
      end
      case (state_ff)
         ST_IDLE: begin
            cx_in  = req_pos_x;
            cy_in  = req_pos_y;
            lim_in = 10'(hw_clamp) * 10'(hw_clamp);
            x0_in  = (req_pos_x >= 8'(hw_clamp)) ? 9'(req_pos_x - 8'(hw_clamp)) : '0;
            y0_in  = (req_pos_y >= 8'(hw_clamp)) ? 9'(req_pos_y - 8'(hw_clamp)) : '0;
            x1_in  = (cx_hi > w_clamp - 1'b1) ? w_clamp - 1'b1 : cx_hi;
            y1_in  = (cy_hi > h_clamp - 1'b1) ? h_clamp - 1'b1 : cy_hi;
         end
         ST_CENTER: begin
            center_in = frame_rd_data;
            bx_in     = x0_ff;
            by_in     = y0_ff;
            wsum_in   = '0;
            for (int j = 0; j < 3; j++) begin
               acc_in[j] = '0;
            end
            drain_in  = 2'd2;
            ch_in     = 2'd0;
         end
         ST_WALK: begin
            v1_in = walk_valid;
            if (row_end) begin
               bx_in = x0_ff;
               by_in = by_ff + 1'b1;
            end else begin
               bx_in = bx_ff + 1'b1;
            end
         end
         ST_DRAIN: drain_in = drain_ff - 1'b1;
         ST_DECIDE: begin
            for (int j = 0; j < 3; j++) begin
               res_in[j] = center_ff[PIXEL_BITS-1-CB*j -: CB];
            end
         end
         ST_DIV_WAIT: bloom_in = div_status.quotient;
         ST_MIX_MUL:  mprod_in = signed'((WEIGHT_BITS+CB+2)'(mix_ff)) *
                                 (WEIGHT_BITS+CB+2)'(diff);
         ST_MIX_ADD: begin
            res_in[ch_ff] = sum_mix[CB+3] ? '0 :
                            (sum_mix > signed'((CB+4)'((1 << CB) - 1))) ? {CB{1'b1}}
                                                                        : sum_mix[CB-1:0];
            ch_in = ch_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
      end
      x0_ff <= x0_in; x1_ff <= x1_in; y0_ff <= y0_in; y1_ff <= y1_in;
      cx_ff <= cx_in; cy_ff <= cy_in; lim_ff <= lim_in;
      bx_ff <= bx_in; by_ff <= by_in;
      center_ff <= center_in;
      wt_ff     <= wt_in;
      wsum_ff   <= wsum_in;
      drain_ff  <= drain_in;
      ch_ff     <= ch_in;
      bloom_ff  <= bloom_in;
      mprod_ff  <= mprod_in;
      for (int j = 0; j < 3; j++) begin
         prod_ff[j] <= prod_in[j];
         acc_ff[j]  <= acc_in[j];
         res_ff[j]  <= res_in[j];
      end
   end

   assign rsp_out_red   = res_ff[0];
   assign rsp_out_green = res_ff[1];
   assign rsp_out_blue  = res_ff[2];

   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy still high after the result item");

   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_FILTER) |=> busy)
      else $error("filter item accepted without raising busy");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_walk_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (!v1_ff && !v2_ff))
      else $error("accumulation pipeline not drained at decision");

endmodule

>>> test/image_bloom_filter_unit_tb.sv
// Testbench of image_bloom_filter_unit: weight loads, pixel writes and filter requests under
// several image, window and blend settings, each result checked against a built-in predictor.
// Depends on ibf_pkg and the RTL of the unit; it reads no file.
`timescale 1ns / 1ps

import ibf_pkg::*;

typedef struct {
   req_kind_type kind;
   bit [7:0]     x;
   bit [7:0]     y;
   bit [7:0]     idx;
   bit [16:0]    val;
   bit [15:0]    r;
   bit [15:0]    g;
   bit [15:0]    b;
} bloom_item_type;

class bloom_scoreboard;
   bit [47:0] frame [65536];
   bit [16:0] weight [256];
   int        width_reg = 256;
   int        height_reg = 256;
   int        half_reg = 0;
   int        mix_reg = 0;
   bit [47:0] pending_pixels [$];
   int        errors = 0;
   int        checked = 0;

   task report(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function void set_reg(csr_index_type i, int v);
      case (i)
         CSR_WIDTH: width_reg = v & 'h1FF;
         CSR_HEIGHT: height_reg = v & 'h1FF;
         CSR_HALF: half_reg = v & 'h1F;
         default: mix_reg = v & 'h1FFFF;
      endcase
   endfunction

   function int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function bit [47:0] bloom_pixel(int cx, int cy);
      int        w, h, hw, x0, x1, y0, y1, d2;
      longint    acc [3];
      longint    wsum, pix, bloom, prod, step, res;
      bit [47:0] centre, p, out;
      w = clip(width_reg, 1, MAX_WIDTH);
      h = clip(height_reg, 1, MAX_HEIGHT);
      hw = clip(half_reg, 0, MAX_HALF_WIDTH);
      x0 = cx - hw < 0 ? 0 : cx - hw;
      x1 = cx + hw > w - 1 ? w - 1 : cx + hw;
      y0 = cy - hw < 0 ? 0 : cy - hw;
      y1 = cy + hw > h - 1 ? h - 1 : cy + hw;
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      wsum = 0;
      for (int by = y0; by <= y1; by++)
         for (int bx = x0; bx <= x1; bx++) begin
            d2 = (cx - bx) * (cx - bx) + (cy - by) * (cy - by);
            if (d2 != 0 && d2 < hw * hw && d2 < 256) begin
               p = frame[by * 256 + bx];
               wsum += weight[d2];
               for (int j = 0; j < 3; j++)
                  acc[j] += longint'(weight[d2]) * p[47 - 16 * j -: 16];
            end
         end
      centre = frame[cy * 256 + cx];
      out = centre;
      if (wsum != 0)
         for (int j = 0; j < 3; j++) begin
            pix = centre[47 - 16 * j -: 16];
            bloom = acc[j] / wsum;
            prod = longint'(mix_reg) * (bloom - pix);
            step = prod >= 0 ? prod / 65536 : -((-prod + 65535) / 65536);
            res = pix + step;
            res = res < 0 ? 0 : (res > 65535 ? 65535 : res);
            out[47 - 16 * j -: 16] = res[15:0];
         end
      return out;
   endfunction

   function void note(bloom_item_type t);
      case (t.kind)
         REQ_LOAD: weight[t.idx] = t.val;
         REQ_WRITE: frame[{t.y, t.x}] = {t.r, t.g, t.b};
         REQ_FILTER: pending_pixels.push_back(bloom_pixel(t.x, t.y));
         default: ;
      endcase
   endfunction

   task check(bit [15:0] r, bit [15:0] g, bit [15:0] b);
      bit [47:0] want;
      if (pending_pixels.size() == 0) begin
         report("unexpected result, red", r, 0);
      end else begin
         want = pending_pixels.pop_front();
         checked++;
         if (r != want[47:32]) report("red", r, want[47:32]);
         if (g != want[31:16]) report("green", g, want[31:16]);
         if (b != want[15:0]) report("blue", b, want[15:0]);
      end
   endtask
endclass

module image_bloom_filter_unit_tb;
   localparam int STALL_LIMIT = 20000;
   localparam int ITEM_TARGET = 450;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = '0;
   logic [7:0]  req_pos_x = '0;
   logic [7:0]  req_pos_y = '0;
   logic [7:0]  req_table_index = '0;
   logic [16:0] req_table_value = '0;
   logic [15:0] req_in_red = '0;
   logic [15:0] req_in_green = '0;
   logic [15:0] req_in_blue = '0;
   logic        rsp_valid;
   logic [15:0] rsp_out_red;
   logic [15:0] rsp_out_green;
   logic [15:0] rsp_out_blue;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   bloom_scoreboard bloom_sb = new();
   bit  pixel_known [65536];
   bit  weight_known [256];
   int  idle_cycles = 0;
   int  sent_filters = 0;
   int  sent_other = 0;

   image_bloom_filter_unit u_top (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         bloom_sb.check(rsp_out_red, rsp_out_green, rsp_out_blue);
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task send(bloom_item_type t);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_type <= t.kind;
      req_pos_x <= t.x;
      req_pos_y <= t.y;
      req_table_index <= t.idx;
      req_table_value <= t.val;
      req_in_red <= t.r;
      req_in_green <= t.g;
      req_in_blue <= t.b;
      do @(posedge clock); while (busy);
      bloom_sb.note(t);
      if (t.kind == REQ_LOAD) weight_known[t.idx] = 1;
      if (t.kind == REQ_WRITE) pixel_known[{t.y, t.x}] = 1;
      if (t.kind == REQ_FILTER) sent_filters++; else sent_other++;
   endtask

   function bloom_item_type random_item(req_kind_type k, int x, int y);
      bloom_item_type t;
      t.kind = k;
      t.x = 8'(x);
      t.y = 8'(y);
      t.idx = 8'($urandom_range(0, 255));
      t.val = $urandom_range(0, 7) == 0 ? 17'd0 : 17'($urandom_range(0, 131071));
      t.r = 16'($urandom);
      t.g = 16'($urandom);
      t.b = 16'($urandom);
      return t;
   endfunction

   task load_weight(int i, int v);
      bloom_item_type t;
      t = random_item(REQ_LOAD, $urandom_range(0, 255), $urandom_range(0, 255));
      t.idx = 8'(i);
      if (v >= 0) t.val = 17'(v);
      send(t);
   endtask

   task write_pixel(int x, int y);
      send(random_item(REQ_WRITE, x, y));
   endtask

   // Every pixel and weight entry that the request will use is written first.
   task filter_at(int cx, int cy);
      int w, h, hw, d2;
      w = bloom_sb.clip(bloom_sb.width_reg, 1, MAX_WIDTH);
      h = bloom_sb.clip(bloom_sb.height_reg, 1, MAX_HEIGHT);
      hw = bloom_sb.clip(bloom_sb.half_reg, 0, MAX_HALF_WIDTH);
      if (!pixel_known[cy * 256 + cx]) write_pixel(cx, cy);
      for (int by = (cy - hw < 0 ? 0 : cy - hw); by <= cy + hw && by < h; by++)
         for (int bx = (cx - hw < 0 ? 0 : cx - hw); bx <= cx + hw && bx < w; bx++) begin
            d2 = (cx - bx) * (cx - bx) + (cy - by) * (cy - by);
            if (d2 != 0 && d2 < hw * hw && d2 < 256) begin
               if (!weight_known[d2]) load_weight(d2, -1);
               if (!pixel_known[by * 256 + bx]) write_pixel(bx, by);
            end
         end
      send(random_item(REQ_FILTER, cx, cy));
   endtask

   task set_reg(csr_index_type i, int v);
      start <= 0;
      while (bloom_sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we <= 1;
      csr_index <= i;
      csr_wdata <= 17'(v);
      @(posedge clock);
      csr_we <= 0;
      bloom_sb.set_reg(i, v);
   endtask

   task setup(int w, int h, int hw, int m);
      set_reg(CSR_WIDTH, w);
      set_reg(CSR_HEIGHT, h);
      set_reg(CSR_HALF, hw);
      set_reg(CSR_MIX, m);
   endtask

   initial begin
      int w, h, roll, base;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: field extremes, every request kind and the special cases.
      setup(8, 8, 3, 32768);
      load_weight(0, 0);
      load_weight(255, 131071);
      load_weight(1, 65536);
      load_weight(4, 0);
      write_pixel(0, 0);
      write_pixel(255, 255);
      send(random_item(REQ_NONE, 255, 255));
      filter_at(0, 0);
      filter_at(7, 7);
      filter_at(255, 255);
      set_reg(CSR_MIX, 131071);
      filter_at(3, 4);
      set_reg(CSR_MIX, 65536);
      filter_at(4, 3);
      set_reg(CSR_HALF, 0);
      filter_at(2, 2);
      setup(0, 511, 31, 0);
      filter_at(0, 10);
      setup(10, 10, 16, 100000);
      filter_at(5, 5);
      setup(256, 256, 2, 65535);
      filter_at(128, 200);

      // Random part.
      base = sent_filters + sent_other;
      for (int phase = 0; phase < 8; phase++) begin
         w = $urandom_range(0, 4) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 20);
         h = $urandom_range(0, 4) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 20);
         setup(w, h, $urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 5),
               $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536));
         w = bloom_sb.clip(w, 1, 32);
         h = bloom_sb.clip(h, 1, 32);
         while (sent_filters + sent_other < base + (phase + 1) * (ITEM_TARGET - base) / 8)
         begin
            roll = $urandom_range(0, 19);
            if (roll < 5)
               write_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
            else if (roll < 8)
               load_weight($urandom_range(0, 255), -1);
            else if (roll < 9)
               send(random_item(REQ_NONE, $urandom_range(0, 255), $urandom_range(0, 255)));
            else if (roll < 11)
               filter_at($urandom_range(0, 255), $urandom_range(0, 255));
            else
               filter_at($urandom_range(0, w - 1), $urandom_range(0, h - 1));
         end
      end

      start <= 0;
      while (bloom_sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d filter requests and %0d loads, writes and ignored items.",
               sent_filters, sent_other);
      $display("Checked %0d results over the directed settings and eight random ones.",
               bloom_sb.checked);
      if (bloom_sb.errors == 0 && bloom_sb.pending_pixels.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
